// ===== hdl/aenv_pkg.sv =====
// shared types and constants of the polyphonic adsr envelope core
// no dependencies; imported by the divider, datapath, controller and top level
`default_nettype none

package aenv_pkg;

    localparam int VOICES_DEF = 64;
    localparam int LEVEL_W    = 16;
    localparam int REL_W      = 20;
    localparam int PRESS_W    = 8;
    localparam int VOICE_W    = 6;

    localparam logic [LEVEL_W-1:0] FULL_LEVEL  = 16'd32768;
    localparam logic [PRESS_W-1:0] PRESS_MAX   = 8'd255;

    // reset values of the configuration registers
    localparam logic [LEVEL_W-1:0] ATTACK_RST  = 16'd137;
    localparam logic [LEVEL_W-1:0] DECAY_RST   = 16'd0;
    localparam logic [LEVEL_W-1:0] SUSTAIN_RST = 16'd32768;
    localparam logic [REL_W-1:0]   RELEASE_RST = 20'd240;

    // configuration register indexes
    localparam logic [1:0] CFG_ATTACK  = 2'd0;
    localparam logic [1:0] CFG_DECAY   = 2'd1;
    localparam logic [1:0] CFG_SUSTAIN = 2'd2;
    localparam logic [1:0] CFG_RELEASE = 2'd3;

    // item modes
    localparam logic [1:0] MODE_TICK = 2'd0;
    localparam logic [1:0] MODE_ON   = 2'd1;
    localparam logic [1:0] MODE_OFF  = 2'd2;

    typedef enum logic [1:0] {
        ST_DONE    = 2'd0,
        ST_ATTACK  = 2'd1,
        ST_DECAY   = 2'd2,
        ST_RELEASE = 2'd3
    } t_stage;

    typedef struct packed {
        logic [1:0]         mode;
        logic [VOICE_W-1:0] voice;
    } t_in;

    typedef struct packed {
        logic [VOICE_W-1:0] voice_out;
        logic [LEVEL_W-1:0] level;
        logic [1:0]         stage;
        logic [PRESS_W-1:0] press_count;
    } t_out;

    typedef struct packed {
        logic [1:0]       addr;
        logic [REL_W-1:0] wdata;
    } t_cfg;

    // one voice as held in the state ram
    typedef struct packed {
        logic [LEVEL_W-1:0] level;
        t_stage             stage;
        logic [PRESS_W-1:0] presses;
        logic [LEVEL_W-1:0] rel_step;
    } t_ent;

    localparam t_ent ENT_RST = '{level: '0, stage: ST_DONE, presses: '0, rel_step: '0};

    // controller to datapath
    typedef struct packed {
        logic load_in;
        logic capture;
        logic calc;
        logic div_start;
        logic div_load;
        logic commit;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic need_div;
        logic div_done;
        logic out_free;
    } t_sta;

endpackage

`default_nettype wire

// ===== hdl/aenv_chan.sv =====
// valid/ready channel carrying one payload beat of type T
// no dependencies
`default_nettype none

interface aenv_chan #(
    parameter type T = logic
) ();
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== hdl/aenv_ram.sv =====
// generic single write port ram with registered read
// no dependencies
`default_nettype none

module aenv_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                                      i_clk,
    input  wire logic                                      i_we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]                          i_wdata,
    input  wire logic                                      i_re,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic      [WIDTH-1:0]                          o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

`default_nettype wire

// ===== hdl/aenv_div.sv =====
// restoring divider, one quotient bit per cycle, for the release step
// depends on aenv_pkg
`default_nettype none

module aenv_div (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_start,
    input  wire logic [aenv_pkg::LEVEL_W-1:0] i_dividend,
    input  wire logic [aenv_pkg::REL_W-1:0]   i_divisor,
    output logic      [aenv_pkg::LEVEL_W-1:0] o_quotient,
    output logic                            o_done
);
    import aenv_pkg::*;

    localparam int CW = $clog2(LEVEL_W);

    logic             r_busy;
    logic             r_done;
    logic [CW-1:0]    r_cnt;
    logic [REL_W-1:0] r_rem;
    logic [LEVEL_W-1:0] r_quo;
    logic [REL_W:0]   w_trial;
    logic             w_fit;

    assign w_trial = {r_rem, r_quo[LEVEL_W-1]};
    assign w_fit   = w_trial >= {1'b0, i_divisor};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CW'(LEVEL_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // quotient bits shift in where dividend bits shift out
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
        end else if (r_busy) begin
            if (w_fit) begin
                r_rem <= REL_W'(w_trial - {1'b0, i_divisor});
            end else begin
                r_rem <= w_trial[REL_W-1:0];
            end
            r_quo <= {r_quo[LEVEL_W-2:0], w_fit};
        end
    end

    assign o_quotient = r_quo;
    assign o_done     = r_done;

`ifndef SYNTHESIS
    a_no_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> !r_busy)
        else $error("divider restarted while busy");
`endif
endmodule

`default_nettype wire

// ===== hdl/aenv_dp.sv =====
// datapath: configuration registers, voice state ram, envelope step logic,
// release divider and output register; depends on aenv_pkg, aenv_ram, aenv_div
`default_nettype none

module aenv_dp #(
    parameter int VOICES = aenv_pkg::VOICES_DEF
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire aenv_pkg::t_cmd i_cmd,
    output aenv_pkg::t_sta      o_sta,
    input  wire aenv_pkg::t_in  i_in_data,
    input  wire logic           i_cfg_valid,
    input  wire aenv_pkg::t_cfg i_cfg_data,
    output logic                o_out_valid,
    input  wire logic           i_out_ready,
    output aenv_pkg::t_out      o_out_data
);
    import aenv_pkg::*;

    localparam int AW = (VOICES > 1) ? $clog2(VOICES) : 1;
    localparam logic [8:0] NVOICE = 9'(VOICES);

    logic [LEVEL_W-1:0] r_attack;
    logic [LEVEL_W-1:0] r_decay;
    logic [LEVEL_W-1:0] r_sustain;
    logic [REL_W-1:0]   r_release;

    logic [1:0]         r_mode;
    logic [VOICE_W-1:0] r_voice;
    logic               r_inrange;
    t_ent               r_ent;
    t_ent               n_ent;
    logic [VOICES-1:0]  r_valid;
    logic               r_out_valid;
    t_out               r_out;

    logic [AW-1:0]      w_raddr;
    logic [AW-1:0]      w_addr;
    logic [$bits(t_ent)-1:0] w_rdata;
    logic               w_we;

    logic [LEVEL_W:0]   w_sum;
    logic signed [LEVEL_W+1:0] w_dec;
    logic signed [LEVEL_W+1:0] w_rel;
    logic [LEVEL_W-1:0] w_sus;
    logic [LEVEL_W-1:0] w_quo;
    logic               w_div_done;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_attack  <= ATTACK_RST;
            r_decay   <= DECAY_RST;
            r_sustain <= SUSTAIN_RST;
            r_release <= RELEASE_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_data.addr)
                CFG_ATTACK:  r_attack  <= i_cfg_data.wdata[LEVEL_W-1:0];
                CFG_DECAY:   r_decay   <= i_cfg_data.wdata[LEVEL_W-1:0];
                CFG_SUSTAIN: r_sustain <= i_cfg_data.wdata[LEVEL_W-1:0];
                CFG_RELEASE: r_release <= i_cfg_data.wdata;
                default: begin
                end
            endcase
        end
    end

    assign w_raddr = AW'(i_in_data.voice);
    assign w_addr  = AW'(r_voice);
    assign w_we    = i_cmd.commit && r_inrange;

    aenv_ram #(
        .WIDTH ($bits(t_ent)),
        .DEPTH (VOICES)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_addr),
        .i_wdata (r_ent),
        .i_re    (i_cmd.load_in),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    aenv_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (r_ent.level),
        .i_divisor  (r_release),
        .o_quotient (w_quo),
        .o_done     (w_div_done)
    );

    // one envelope step on the captured voice
    assign w_sum = {1'b0, r_ent.level} + {1'b0, r_attack};
    assign w_dec = $signed({2'b00, r_ent.level}) - $signed({2'b00, r_decay});
    assign w_rel = $signed({2'b00, r_ent.level}) - $signed({2'b00, r_ent.rel_step});
    assign w_sus = (r_sustain > FULL_LEVEL) ? FULL_LEVEL : r_sustain;

    always_comb begin
        n_ent = r_ent;
        case (r_mode)
            MODE_TICK: begin
                case (r_ent.stage)
                    ST_ATTACK: begin
                        if (w_sum >= {1'b0, FULL_LEVEL}) begin
                            n_ent.level = FULL_LEVEL;
                            n_ent.stage = ST_DECAY;
                        end else begin
                            n_ent.level = w_sum[LEVEL_W-1:0];
                        end
                    end
                    ST_DECAY: begin
                        if (w_dec < $signed({2'b00, w_sus})) begin
                            n_ent.level = w_sus;
                        end else begin
                            n_ent.level = w_dec[LEVEL_W-1:0];
                        end
                    end
                    ST_RELEASE: begin
                        if (w_rel <= 0) begin
                            n_ent.level = '0;
                            n_ent.stage = ST_DONE;
                        end else begin
                            n_ent.level = w_rel[LEVEL_W-1:0];
                        end
                    end
                    default: begin
                    end
                endcase
            end
            MODE_ON: begin
                if (r_ent.presses == '0) begin
                    n_ent.stage = ST_ATTACK;
                end
                if (r_ent.presses != PRESS_MAX) begin
                    n_ent.presses = r_ent.presses + 1'b1;
                end
            end
            MODE_OFF: begin
                if (r_ent.presses != '0) begin
                    if (r_ent.presses == PRESS_W'(1)) begin
                        // immediate release; the divider overwrites this otherwise
                        n_ent.rel_step = (r_ent.level == '0) ? LEVEL_W'(1) : r_ent.level;
                        n_ent.stage    = ST_RELEASE;
                    end
                    n_ent.presses = r_ent.presses - 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_mode    <= i_in_data.mode;
            r_voice   <= i_in_data.voice;
            r_inrange <= {3'b000, i_in_data.voice} < NVOICE;
        end
        if (i_cmd.capture) begin
            r_ent <= r_valid[w_addr] ? t_ent'(w_rdata) : ENT_RST;
        end else if (i_cmd.calc) begin
            r_ent <= n_ent;
        end else if (i_cmd.div_load) begin
            r_ent.rel_step <= (w_quo == '0) ? LEVEL_W'(1) : w_quo;
        end
    end

    // entries never written read as the reset voice
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (w_we) begin
            r_valid[w_addr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.commit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_out.voice_out   <= r_voice;
            r_out.level       <= r_inrange ? r_ent.level   : '0;
            r_out.stage       <= r_inrange ? r_ent.stage   : ST_DONE;
            r_out.press_count <= r_inrange ? r_ent.presses : '0;
        end
    end

    // a voice outside the ram never starts the divider
    assign o_sta.need_div = (r_mode == MODE_OFF) && (r_ent.presses == PRESS_W'(1))
                            && (r_release != '0) && r_inrange;
    assign o_sta.div_done = w_div_done;
    assign o_sta.out_free = !r_out_valid || i_out_ready;
    assign o_out_valid    = r_out_valid;
    assign o_out_data     = r_out;

`ifndef SYNTHESIS
    a_level_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out.level <= FULL_LEVEL))
        else $error("reported level above full scale");
    a_commit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.commit |-> (!r_out_valid || i_out_ready))
        else $error("result overwritten before it was taken");
`endif
endmodule

`default_nettype wire

// ===== hdl/aenv_ctrl.sv =====
// controller: sequences read, step, optional release division and write-back
// depends on aenv_pkg
`default_nettype none

module aenv_ctrl (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_in_valid,
    output logic                o_in_ready,
    input  wire aenv_pkg::t_sta i_sta,
    output aenv_pkg::t_cmd      o_cmd
);
    import aenv_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOOK,
        S_CALC,
        S_DIV,
        S_FIN
    } t_state;

    t_state r_state;

    assign o_in_ready       = (r_state == S_IDLE);
    assign o_cmd.load_in    = o_in_ready && i_in_valid;
    assign o_cmd.capture    = (r_state == S_LOOK);
    assign o_cmd.calc       = (r_state == S_CALC);
    assign o_cmd.div_start  = (r_state == S_CALC) && i_sta.need_div;
    assign o_cmd.div_load   = (r_state == S_DIV) && i_sta.div_done;
    assign o_cmd.commit     = (r_state == S_FIN) && i_sta.out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) r_state <= S_LOOK;
                end
                S_LOOK: r_state <= S_CALC;
                S_CALC: r_state <= i_sta.need_div ? S_DIV : S_FIN;
                S_DIV: begin
                    if (i_sta.div_done) r_state <= S_FIN;
                end
                S_FIN: begin
                    if (i_sta.out_free) r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

`ifndef SYNTHESIS
    a_done_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_sta.div_done |-> (r_state == S_DIV))
        else $error("divider finished outside the division state");
    a_accept_to_calc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |-> ##2 (r_state == S_CALC))
        else $error("accepted beat did not reach the step state");
`endif
endmodule

`default_nettype wire

// ===== hdl/polyphonic_adsr_envelope_core.sv =====
// Linear attack/decay/release envelopes for VOICES voices, one state word per
// voice in a single ram. Each input beat passes from acceptance to its result
// through ram read, capture, step, and write-back with the output register load;
// a note off that releases the last press with the release setting non-zero also
// runs the serial 16-bit divider between step and write-back. One item
// is worked on at a time; the next beat is accepted while a result still waits
// in the output register, and a stalled output holds the following item in its
// write-back cycle. Configuration writes are taken every cycle.
// depends on aenv_pkg, aenv_chan, aenv_ctrl, aenv_dp
`default_nettype none

module polyphonic_adsr_envelope_core #(
    parameter int VOICES = aenv_pkg::VOICES_DEF
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    aenv_chan.sink    i_in,
    aenv_chan.sink    i_cfg,
    aenv_chan.source  o_out
);
    import aenv_pkg::*;

    t_cmd w_cmd;
    t_sta w_sta;
    logic w_in_ready;
    logic w_out_valid;
    t_out w_out_data;

    aenv_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (w_in_ready),
        .i_sta      (w_sta),
        .o_cmd      (w_cmd)
    );

    aenv_dp #(
        .VOICES (VOICES)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_sta       (w_sta),
        .i_in_data   (i_in.data),
        .i_cfg_valid (i_cfg.valid),
        .i_cfg_data  (i_cfg.data),
        .o_out_valid (w_out_valid),
        .i_out_ready (o_out.ready),
        .o_out_data  (w_out_data)
    );

    assign i_in.ready  = w_in_ready;
    assign i_cfg.ready = 1'b1;
    assign o_out.valid = w_out_valid;
    assign o_out.data  = w_out_data;
endmodule

`default_nettype wire
